// File: rtl/core/i2cm_pkg.sv
package i2cm_pkg;

  // Command codes on the input channel
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // Configuration register map (byte address 4*index)
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_HALF_BIT    = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  localparam logic [15:0] HALF_BIT_RESET    = 16'd100;
  localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

  typedef struct packed {
    logic [15:0] half_bit_ticks;
    logic [7:0]  ack_timeout_polls;
  } cfg_t;

endpackage

// File: rtl/core/i2cm_if.sv
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, cmd, tx_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, cmd, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_pull_low;
  logic       busy_res;
  logic       done_res;
  logic       ack_missing;
  logic [7:0] rx_byte;

  modport source (output valid, scl_level, sda_pull_low, busy_res, done_res, ack_missing,
                  rx_byte, input ready);
  modport sink   (input valid, scl_level, sda_pull_low, busy_res, done_res, ack_missing,
                  rx_byte, output ready);
endinterface

// File: rtl/core/i2cm_cfg.sv
module i2cm_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [i2cm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output i2cm_pkg::cfg_t                   cfg_o
);
  import i2cm_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_bit_ticks    <= HALF_BIT_RESET;
      cfg_q.ack_timeout_polls <= ACK_TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_HALF_BIT:    cfg_q.half_bit_ticks    <= pwdata[15:0];
        REG_ACK_TIMEOUT: cfg_q.ack_timeout_polls <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HALF_BIT:    prdata = {16'd0, cfg_q.half_bit_ticks};
      REG_ACK_TIMEOUT: prdata = {24'd0, cfg_q.ack_timeout_polls};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/i2c_master_byte_engine.sv
// Channel  | Dir | Handshake     | Payload
// in_i     | in  | valid/ready   | cmd, tx_byte, send_ack, sda_in (one timing tick)
// res_o    | out | valid/ready   | scl_level, sda_pull_low, busy_res, done_res,
//          |     |               | ack_missing, rx_byte (line state after the tick)
// apb      | in  | psel/penable  | half_bit_ticks @0x0, ack_timeout_polls @0x4
//
// Every accepted tick gives exactly one result, offered from the next cycle.
// One tick is taken per cycle; the phase machine and its counters advance on each
// accepted tick, and the result register lets the next tick enter in the cycle the held
// result is taken. in_i.ready drops only while a result is held and res_o.ready is low.
// Reset leaves the engine idle with both lines released and the registers at
// their reset values (100 ticks per unit, 250 polls).
module i2c_master_byte_engine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  i2cm_in_if.sink                         in_i,
  i2cm_out_if.source                      res_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [i2cm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import i2cm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_S_HI   = 4'd1,
    PH_S_LO   = 4'd2,
    PH_P_LO   = 4'd3,
    PH_P_HI   = 4'd4,
    PH_T_SET  = 4'd5,
    PH_T_HI   = 4'd6,
    PH_T_LO   = 4'd7,
    PH_W_REL  = 4'd8,
    PH_W_HI   = 4'd9,
    PH_W_POLL = 4'd10,
    PH_R_LO   = 4'd11,
    PH_R_HI   = 4'd12,
    PH_K_LO   = 4'd13,
    PH_K_HI   = 4'd14
  } phase_e;

  cfg_t cfg;

  i2cm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Engine state
  phase_e      phase_q, phase_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] dly_q, dly_d;
  logic [1:0]  unit_q, unit_d;
  logic [7:0]  poll_q, poll_d;
  logic        scl_q, scl_d;
  logic        sda_hi_q, sda_hi_d;
  logic        err_q, err_d;
  logic        ack_sel_q, ack_sel_d;
  logic [7:0]  rx_q, rx_d;
  logic        done;

  // Result register
  logic        res_valid_q;
  logic        res_scl_q, res_pull_q, res_busy_q, res_done_q, res_err_q;
  logic [7:0]  res_rx_q;

  logic        accept;

  // Delay unit timing
  logic [15:0] half_ticks;
  logic [15:0] dly_inc;
  logic [2:0]  unit_inc;
  logic [2:0]  unit_need;
  logic        unit_end;
  logic        wait_hit;
  logic [3:0]  bit_inc;
  logic [7:0]  shift_nxt;

  assign in_i.ready = !res_valid_q || res_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign half_ticks = (cfg.half_bit_ticks == 16'd0) ? 16'd1 : cfg.half_bit_ticks;
  assign dly_inc    = dly_q + 16'd1;
  assign unit_end   = dly_inc >= half_ticks;
  assign unit_inc   = {1'b0, unit_q} + 3'd1;
  assign bit_inc    = bit_q + 4'd1;
  assign shift_nxt  = {shift_q[6:0], 1'b0};

  always_comb begin
    unique case (phase_q)
      PH_S_HI, PH_S_LO, PH_P_LO, PH_P_HI:           unit_need = 3'd4;
      PH_W_REL, PH_W_HI, PH_R_HI:                   unit_need = 3'd1;
      default:                                      unit_need = 3'd2;
    endcase
  end

  assign wait_hit = unit_end && (unit_inc >= unit_need);

  always_comb begin
    phase_d   = phase_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    poll_d    = poll_q;
    scl_d     = scl_q;
    sda_hi_d  = sda_hi_q;
    err_d     = err_q;
    ack_sel_d = ack_sel_q;
    rx_d      = rx_q;
    done      = 1'b0;
    // Count the running delay; a phase change below restarts it.
    dly_d     = unit_end ? 16'd0 : dly_inc;
    unit_d    = unit_end ? unit_inc[1:0] : unit_q;

    unique case (phase_q)
      PH_IDLE: begin
        dly_d  = 16'd0;
        unit_d = 2'd0;
        case (in_i.cmd)
          CMD_START: begin
            scl_d = 1'b1; sda_hi_d = 1'b1; phase_d = PH_S_HI;
          end
          CMD_STOP: begin
            scl_d = 1'b0; sda_hi_d = 1'b0; phase_d = PH_P_LO;
          end
          CMD_WRITE: begin
            err_d    = 1'b0;
            shift_d  = in_i.tx_byte;
            bit_d    = 4'd0;
            scl_d    = 1'b0;
            sda_hi_d = in_i.tx_byte[7];
            phase_d  = PH_T_SET;
          end
          CMD_READ: begin
            ack_sel_d = in_i.send_ack;
            shift_d   = 8'd0;
            bit_d     = 4'd0;
            scl_d     = 1'b0;
            sda_hi_d  = 1'b1;
            phase_d   = PH_R_LO;
          end
          default: ;
        endcase
      end
      PH_S_HI: if (wait_hit) begin
        sda_hi_d = 1'b0; phase_d = PH_S_LO;
      end
      PH_S_LO: if (wait_hit) begin
        scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
      end
      PH_P_LO: if (wait_hit) begin
        scl_d = 1'b1; sda_hi_d = 1'b1; phase_d = PH_P_HI;
      end
      PH_P_HI: if (wait_hit) begin
        phase_d = PH_IDLE; done = 1'b1;
      end
      PH_T_SET: if (wait_hit) begin
        scl_d = 1'b1; phase_d = PH_T_HI;
      end
      PH_T_HI: if (wait_hit) begin
        scl_d = 1'b0; phase_d = PH_T_LO;
      end
      PH_T_LO: if (wait_hit) begin
        shift_d = shift_nxt;
        bit_d   = bit_inc;
        scl_d   = 1'b0;
        if (bit_inc >= 4'd8) begin
          sda_hi_d = 1'b1; phase_d = PH_W_REL;
        end else begin
          sda_hi_d = shift_nxt[7]; phase_d = PH_T_SET;
        end
      end
      PH_W_REL: if (wait_hit) begin
        scl_d = 1'b1; sda_hi_d = 1'b1; phase_d = PH_W_HI;
      end
      PH_W_HI: if (wait_hit) begin
        poll_d = 8'd0; phase_d = PH_W_POLL;
      end
      PH_W_POLL: begin
        dly_d  = 16'd0;
        unit_d = 2'd0;
        if (!in_i.sda_in) begin
          // Slave acknowledged: drop SCL and finish the write
          err_d = 1'b0; scl_d = 1'b0; sda_hi_d = 1'b1;
          phase_d = PH_IDLE; done = 1'b1;
        end else if (poll_q >= cfg.ack_timeout_polls) begin
          // No acknowledge in time: flag it and issue a stop
          err_d = 1'b1; scl_d = 1'b0; sda_hi_d = 1'b0; phase_d = PH_P_LO;
        end else begin
          poll_d = poll_q + 8'd1;
        end
      end
      PH_R_LO: if (wait_hit) begin
        shift_d = {shift_q[6:0], in_i.sda_in};
        scl_d = 1'b1; sda_hi_d = 1'b1; phase_d = PH_R_HI;
      end
      PH_R_HI: if (wait_hit) begin
        bit_d = bit_inc;
        scl_d = 1'b0;
        if (bit_inc >= 4'd8) begin
          rx_d = shift_q; sda_hi_d = !ack_sel_q; phase_d = PH_K_LO;
        end else begin
          sda_hi_d = 1'b1; phase_d = PH_R_LO;
        end
      end
      PH_K_LO: if (wait_hit) begin
        scl_d = 1'b1; phase_d = PH_K_HI;
      end
      PH_K_HI: if (wait_hit) begin
        scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    if (phase_d != phase_q) begin
      dly_d  = 16'd0;
      unit_d = 2'd0;
    end
  end

  // Advance the engine and capture the result on each accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_q       <= 4'd0;
      shift_q     <= 8'd0;
      dly_q       <= 16'd0;
      unit_q      <= 2'd0;
      poll_q      <= 8'd0;
      scl_q       <= 1'b1;
      sda_hi_q    <= 1'b1;
      err_q       <= 1'b0;
      ack_sel_q   <= 1'b0;
      rx_q        <= 8'd0;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q   <= phase_d;
        bit_q     <= bit_d;
        shift_q   <= shift_d;
        dly_q     <= dly_d;
        unit_q    <= unit_d;
        poll_q    <= poll_d;
        scl_q     <= scl_d;
        sda_hi_q  <= sda_hi_d;
        err_q     <= err_d;
        ack_sel_q <= ack_sel_d;
        rx_q      <= rx_d;
      end
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: no reset needed, qualified by res_valid_q.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_scl_q  <= scl_d;
      res_pull_q <= !sda_hi_d;
      res_busy_q <= (phase_d != PH_IDLE);
      res_done_q <= done;
      res_err_q  <= err_d;
      res_rx_q   <= rx_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.scl_level    = res_scl_q;
  assign res_o.sda_pull_low = res_pull_q;
  assign res_o.busy_res     = res_busy_q;
  assign res_o.done_res     = res_done_q;
  assign res_o.ack_missing  = res_err_q;
  assign res_o.rx_byte      = res_rx_q;

  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.done_res && res_o.busy_res))
    else $error("done and busy reported together");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |-> !in_i.ready)
    else $error("tick accepted over a stalled result");

  a_idle_timer_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (dly_q == 16'd0 && unit_q == 2'd0))
    else $error("delay timer running while idle");

  a_poll_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_W_POLL) |-> (poll_q <= cfg.ack_timeout_polls))
    else $error("poll count past timeout");

endmodule

// File: dv/i2cm_line_watch.sv
`timescale 1ns / 1ps

module i2cm_line_watch
  import i2cm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  i2cm_in_if                    tick_i,
  i2cm_out_if                   line_i,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int unsigned           bad_lines_o,
  output int unsigned           lines_owed_o
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_S_HI, PH_S_LO, PH_P_LO, PH_P_HI, PH_T_SET, PH_T_HI, PH_T_LO,
    PH_W_REL, PH_W_HI, PH_W_POLL, PH_R_LO, PH_R_HI, PH_K_LO, PH_K_HI
  } phase_e;

  typedef struct packed {
    logic       scl;
    logic       pull_low;
    logic       busy;
    logic       done;
    logic       err;
    logic [7:0] rx;
  } line_t;

  cfg_t        cfg;
  phase_e      ph;
  logic [3:0]  bit_cnt;
  logic [7:0]  shift_q;
  logic [15:0] tick_cnt;
  logic [2:0]  unit_cnt;
  logic [7:0]  poll_cnt;
  logic        scl_q;
  logic        sda_rel_q;
  logic        err_q;
  logic        ack_q;
  logic [7:0]  rx_q;
  line_t       owed_q[$];
  int unsigned bad_lines;

  function automatic void clear_engine();
    cfg.half_bit_ticks    = HALF_BIT_RESET;
    cfg.ack_timeout_polls = ACK_TIMEOUT_RESET;
    ph        = PH_IDLE;
    bit_cnt   = '0;
    shift_q   = '0;
    tick_cnt  = '0;
    unit_cnt  = '0;
    poll_cnt  = '0;
    scl_q     = 1'b1;
    sda_rel_q = 1'b1;
    err_q     = 1'b0;
    ack_q     = 1'b0;
    rx_q      = '0;
  endfunction

  function automatic void drive_lines(logic scl, logic sda_rel);
    scl_q     = scl;
    sda_rel_q = sda_rel;
  endfunction

  function automatic void goto_phase(phase_e p);
    ph       = p;
    tick_cnt = '0;
    unit_cnt = '0;
  endfunction

  function automatic void open_stop();
    drive_lines(1'b0, 1'b0);
    goto_phase(PH_P_LO);
  endfunction

  // count one tick; true when the phase of `units` delay units is over
  function automatic bit unit_elapsed(int unsigned units);
    logic [15:0] span;
    span = (cfg.half_bit_ticks == 16'd0) ? 16'd1 : cfg.half_bit_ticks;
    tick_cnt++;
    if (tick_cnt >= span) begin
      tick_cnt = '0;
      unit_cnt++;
      if (unit_cnt >= units) begin
        unit_cnt = '0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic line_t step_engine(logic [2:0] cmd, logic [7:0] tx, logic send_ack,
                                        logic sda);
    line_t r;
    logic  done;
    done = 1'b0;
    case (ph)
      PH_IDLE: begin
        if (cmd == CMD_START) begin
          drive_lines(1'b1, 1'b1);
          goto_phase(PH_S_HI);
        end else if (cmd == CMD_STOP) begin
          open_stop();
        end else if (cmd == CMD_WRITE) begin
          err_q   = 1'b0;
          shift_q = tx;
          bit_cnt = '0;
          drive_lines(1'b0, tx[7]);
          goto_phase(PH_T_SET);
        end else if (cmd == CMD_READ) begin
          ack_q   = send_ack;
          shift_q = '0;
          bit_cnt = '0;
          drive_lines(1'b0, 1'b1);
          goto_phase(PH_R_LO);
        end
      end
      PH_S_HI: if (unit_elapsed(4)) begin
        drive_lines(1'b1, 1'b0);
        goto_phase(PH_S_LO);
      end
      PH_S_LO: if (unit_elapsed(4)) begin
        drive_lines(1'b0, 1'b0);
        goto_phase(PH_IDLE);
        done = 1'b1;
      end
      PH_P_LO: if (unit_elapsed(4)) begin
        drive_lines(1'b1, 1'b1);
        goto_phase(PH_P_HI);
      end
      PH_P_HI: if (unit_elapsed(4)) begin
        goto_phase(PH_IDLE);
        done = 1'b1;
      end
      PH_T_SET: if (unit_elapsed(2)) begin
        drive_lines(1'b1, sda_rel_q);
        goto_phase(PH_T_HI);
      end
      PH_T_HI: if (unit_elapsed(2)) begin
        drive_lines(1'b0, sda_rel_q);
        goto_phase(PH_T_LO);
      end
      PH_T_LO: if (unit_elapsed(2)) begin
        shift_q = shift_q << 1;
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) begin
          drive_lines(1'b0, 1'b1);
          goto_phase(PH_W_REL);
        end else begin
          drive_lines(1'b0, shift_q[7]);
          goto_phase(PH_T_SET);
        end
      end
      PH_W_REL: if (unit_elapsed(1)) begin
        drive_lines(1'b1, 1'b1);
        goto_phase(PH_W_HI);
      end
      PH_W_HI: if (unit_elapsed(1)) begin
        poll_cnt = '0;
        goto_phase(PH_W_POLL);
      end
      PH_W_POLL: begin
        if (!sda) begin
          err_q = 1'b0;
          drive_lines(1'b0, 1'b1);
          goto_phase(PH_IDLE);
          done = 1'b1;
        end else if (poll_cnt >= cfg.ack_timeout_polls) begin
          err_q = 1'b1;
          open_stop();
        end else begin
          poll_cnt = poll_cnt + 8'd1;
        end
      end
      PH_R_LO: if (unit_elapsed(2)) begin
        shift_q = {shift_q[6:0], sda};
        drive_lines(1'b1, 1'b1);
        goto_phase(PH_R_HI);
      end
      PH_R_HI: if (unit_elapsed(1)) begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) begin
          rx_q = shift_q;
          drive_lines(1'b0, !ack_q);
          goto_phase(PH_K_LO);
        end else begin
          drive_lines(1'b0, 1'b1);
          goto_phase(PH_R_LO);
        end
      end
      PH_K_LO: if (unit_elapsed(2)) begin
        drive_lines(1'b1, sda_rel_q);
        goto_phase(PH_K_HI);
      end
      PH_K_HI: if (unit_elapsed(2)) begin
        drive_lines(1'b0, sda_rel_q);
        goto_phase(PH_IDLE);
        done = 1'b1;
      end
      default: goto_phase(PH_IDLE);
    endcase
    r.scl      = scl_q;
    r.pull_low = !sda_rel_q;
    r.busy     = (ph != PH_IDLE);
    r.done     = done;
    r.err      = err_q;
    r.rx       = rx_q;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
    $display("%0t ns: line mismatch on %s: got %0h, want %0h", $time, field, got, want);
    bad_lines++;
  endtask

  task automatic check_line(line_t got);
    line_t want;
    if (owed_q.size() == 0) begin
      report_mismatch("unexpected result", 8'd0, 8'd0);
    end else begin
      want = owed_q.pop_front();
      if (got.scl !== want.scl)           report_mismatch("scl_level", got.scl, want.scl);
      if (got.pull_low !== want.pull_low) report_mismatch("sda_pull_low", got.pull_low,
                                                          want.pull_low);
      if (got.busy !== want.busy)         report_mismatch("busy_res", got.busy, want.busy);
      if (got.done !== want.done)         report_mismatch("done_res", got.done, want.done);
      if (got.err !== want.err)           report_mismatch("ack_missing", got.err, want.err);
      if (got.rx !== want.rx)             report_mismatch("rx_byte", got.rx, want.rx);
    end
  endtask

  initial bad_lines = 0;

  // result first: a result taken at this edge never belongs to the tick taken with it
  always @(posedge clk_i or negedge rst_ni) begin
    line_t got;
    if (!rst_ni) begin
      clear_engine();
      owed_q.delete();
    end else begin
      if (line_i.valid && line_i.ready) begin
        got.scl      = line_i.scl_level;
        got.pull_low = line_i.sda_pull_low;
        got.busy     = line_i.busy_res;
        got.done     = line_i.done_res;
        got.err      = line_i.ack_missing;
        got.rx       = line_i.rx_byte;
        check_line(got);
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_HALF_BIT) cfg.half_bit_ticks = pwdata[15:0];
        else                          cfg.ack_timeout_polls = pwdata[7:0];
      end
      if (tick_i.valid && tick_i.ready)
        owed_q.push_back(step_engine(tick_i.cmd, tick_i.tx_byte, tick_i.send_ack,
                                     tick_i.sda_in));
    end
    lines_owed_o = owed_q.size();
  end

  assign bad_lines_o = bad_lines;

endmodule

// File: dv/tb_i2c_master_byte_engine.sv
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine;
  import i2cm_pkg::*;

  // SDA behavior seen by the engine over one command
  typedef enum int unsigned {
    SDA_RANDOM, SDA_MOSTLY_HIGH, SDA_HIGH, SDA_LOW, SDA_MOSTLY_LOW
  } sda_prof_e;

  // receiver back-pressure styles, one per window
  typedef enum int unsigned {
    RX_STEADY, RX_PATTERN, RX_SPARSE, RX_HOLDOFF
  } rx_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  i2cm_in_if  tick_if ();
  i2cm_out_if line_if ();

  int unsigned bad_lines;
  int unsigned lines_owed;
  int unsigned done_seen;
  logic        last_busy;
  int unsigned burst_left = 0;
  bit          quiet = 1'b0;
  int unsigned stall_win = 0;
  rx_mode_e    stall_mode = RX_STEADY;
  logic [31:0] stall_pat = '1;

  i2c_master_byte_engine dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (tick_if),
    .res_o   (line_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  i2cm_line_watch watch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick_if),
    .line_i       (line_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .bad_lines_o  (bad_lines),
    .lines_owed_o (lines_owed)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Track what the engine reports so the sender knows when a command has
  // finished and whether the engine is idle before a register write.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_seen <= 0;
      last_busy <= 1'b0;
    end else if (line_if.valid && line_if.ready) begin
      done_seen <= done_seen + line_if.done_res;
      last_busy <= line_if.busy_res;
    end
  end

  // Receiver: pick a stall style for a window of cycles, rotate the pattern
  // word every cycle. The hold-off style ends each window with a long stall.
  always @(negedge clk_i) begin
    if (stall_win == 0) begin
      stall_mode = rx_mode_e'($urandom_range(0, 3));
      stall_win  = $urandom_range(16, 80);
      stall_pat  = $urandom;
    end
    stall_win--;
    stall_pat = {stall_pat[30:0], stall_pat[31]};
    case (stall_mode)
      RX_STEADY:  line_if.ready = 1'b1;
      RX_PATTERN: line_if.ready = stall_pat[0];
      RX_SPARSE:  line_if.ready = stall_pat[0] | stall_pat[7];
      default:    line_if.ready = (stall_win > 12);
    endcase
  end

  function automatic logic pick_sda(sda_prof_e prof);
    case (prof)
      SDA_MOSTLY_HIGH: return $urandom_range(0, 47) != 0;
      SDA_HIGH:        return 1'b1;
      SDA_LOW:         return 1'b0;
      SDA_MOSTLY_LOW:  return $urandom_range(0, 7) == 0;
      default:         return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Present one tick and hold it until the transfer happens. Called and
  // returning at a falling edge; a new burst may open with a gap of idle cycles.
  task automatic send_tick(logic [2:0] cmd, logic [7:0] tx, logic ack, logic sda);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        tick_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    tick_if.valid    = 1'b1;
    tick_if.cmd      = cmd;
    tick_if.tx_byte  = tx;
    tick_if.send_ack = ack;
    tick_if.sda_in   = sda;
    do @(posedge clk_i); while (!(tick_if.valid && tick_if.ready));
    @(negedge clk_i);
  endtask

  // Issue a command, then advance the engine with filler ticks until a done
  // shows up. Filler may carry stray commands (1 in `noise`), which the
  // engine must ignore while busy.
  task automatic run_cmd(logic [2:0] cmd, logic [7:0] tx, logic ack, sda_prof_e prof,
                         int unsigned noise);
    int unsigned snap;
    logic [2:0]  fill;
    snap = done_seen;
    send_tick(cmd, tx, ack, pick_sda(prof));
    if (cmd >= CMD_START && cmd <= CMD_READ) begin
      while (done_seen == snap) begin
        fill = (noise != 0 && $urandom_range(1, noise) == 1) ? 3'($urandom_range(1, 7))
                                                             : CMD_NONE;
        send_tick(fill, 8'($urandom), 1'($urandom), pick_sda(prof));
      end
    end
  endtask

  // Drop valid and wait for every owed result; if a stray command left the
  // engine busy, keep ticking until it reports idle, then let it settle.
  task automatic settle();
    while (1) begin
      tick_if.valid = 1'b0;
      while (lines_owed != 0) @(negedge clk_i);
      if (!last_busy) break;
      send_tick(CMD_NONE, 8'd0, 1'b0, 1'($urandom_range(0, 1)));
    end
    tick_if.valid = 1'b0;
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CFG_ADDR_W'(idx) << 2;
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_timing(logic [15:0] half_bit, logic [7:0] polls);
    settle();
    write_reg(REG_HALF_BIT, {16'd0, half_bit});
    write_reg(REG_ACK_TIMEOUT, {24'd0, polls});
  endtask

  function automatic logic [7:0] data_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly acknowledged writes, the rest with any SDA behavior
  function automatic sda_prof_e write_prof();
    if ($urandom_range(0, 9) < 7) return SDA_MOSTLY_LOW;
    return sda_prof_e'($urandom_range(0, 4));
  endfunction

  // One bus exchange: start, address, one to three data bytes, stop. Address bit 0
  // picks reads; the last read byte gets a NACK.
  task automatic run_bus_sequence(output int unsigned issued);
    logic [7:0]  addr;
    int unsigned n;
    addr = 8'($urandom);
    n    = $urandom_range(1, 3);
    run_cmd(CMD_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 24);
    run_cmd(CMD_WRITE, addr, 1'($urandom), write_prof(), 24);
    for (int unsigned i = 0; i < n; i++) begin
      if (addr[0]) run_cmd(CMD_READ, 8'($urandom), i != n - 1, SDA_RANDOM, 24);
      else         run_cmd(CMD_WRITE, data_byte(), 1'($urandom), write_prof(), 24);
    end
    run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, 24);
    issued = n + 3;
  endtask

  task automatic run_phase(logic [15:0] half_bit, logic [7:0] polls, int unsigned ncmd);
    int unsigned issued;
    int unsigned got;
    set_timing(half_bit, polls);
    quiet  = ($urandom_range(0, 2) == 0);
    issued = 0;
    while (issued < ncmd) begin
      if ($urandom_range(0, 6) == 0) begin
        // lone command of any code, unknown ones included
        run_cmd(3'($urandom_range(0, 7)), data_byte(), 1'($urandom),
                sda_prof_e'($urandom_range(0, 4)), 16);
        issued++;
      end else begin
        run_bus_sequence(got);
        issued += got;
      end
      // hold the sender now and then until the result stream is drained
      if ($urandom_range(0, 30) == 0) begin
        tick_if.valid = 1'b0;
        while (lines_owed != 0) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    #20_000_000;
    $display("i2c_master_byte_engine regression: fail");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    tick_if.valid    = 1'b0;
    tick_if.cmd      = CMD_NONE;
    tick_if.tx_byte  = '0;
    tick_if.send_ack = 1'b0;
    tick_if.sda_in   = 1'b1;
    line_if.ready    = 1'b1;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: an idle tick at the reset timing, then each command and its
    // corner cases at a short unit.
    run_cmd(CMD_NONE, 8'h00, 1'b0, SDA_HIGH, 0);

    set_timing(16'd1, 8'd2);
    run_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0);
    run_cmd(CMD_WRITE, 8'h00, 1'b0, SDA_LOW, 0);         // acknowledged at first poll
    run_cmd(CMD_WRITE, 8'hFF, 1'b1, SDA_HIGH, 0);        // no ack: error and own stop
    run_cmd(CMD_READ, 8'h00, 1'b1, SDA_HIGH, 0);         // all ones, then ACK
    run_cmd(CMD_READ, 8'hFF, 0, SDA_LOW, 0);             // all zeros, then NACK
    run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);
    run_cmd(3'd5, 8'hA5, 1'b1, SDA_RANDOM, 0);           // unknown codes do nothing
    run_cmd(3'd6, 8'h5A, 1'b0, SDA_RANDOM, 0);
    run_cmd(3'd7, 8'hC3, 1'b1, SDA_RANDOM, 0);
    // write clears the error; commands while busy ignored
    run_cmd(CMD_WRITE, 8'h5A, 1'b1, SDA_MOSTLY_LOW, 2);

    set_timing(16'd1, 8'd0);
    run_cmd(CMD_WRITE, 8'h3C, 1'b0, SDA_HIGH, 0);        // zero polls tolerated

    set_timing(16'd0, 8'd4);                             // zero unit acts as one
    run_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0);
    run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);

    // Largest values: only idle ticks, a full command would take too long.
    set_timing(16'hFFFF, 8'hFF);
    run_cmd(CMD_NONE, 8'hFF, 1'b1, SDA_RANDOM, 0);
    run_cmd(3'd7, 8'h00, 1'b0, SDA_RANDOM, 0);

    // Random: a short run of bus exchanges and lone commands at a short unit.
    run_phase(16'd1, 8'd1, 4);

    // drain, then let the engine idle before the verdict
    tick_if.valid = 1'b0;
    while (lines_owed != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (bad_lines == 0) begin
      $display("i2c_master_byte_engine regression: pass");
    end else begin
      $display("i2c_master_byte_engine regression: fail");
    end
    $finish;
  end

endmodule
